// ----- rtl/core/stepper_ramp_pulse_generator_core_defines.svh -----
// Assertion macros for the stepper ramp pulse generator core.
// Included by the top level only; no other dependencies.
`ifndef STEPPER_RAMP_PULSE_GENERATOR_CORE_DEFINES_SVH
`define STEPPER_RAMP_PULSE_GENERATOR_CORE_DEFINES_SVH

// condition must hold at every edge outside reset
`define SRPG_ASSERT_HOLDS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the same cycle as the antecedent
`define SRPG_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/srpg_pkg.sv -----
// Shared types and constants for the stepper ramp pulse generator core.
// No dependencies; used by the channel interfaces and the top level.
package srpg_pkg;

   localparam int TIME_DIVISOR_DEFAULT = 50000;

   localparam logic [15:0] RESET_ACCEL_RATE      = 16'd4;
   localparam logic [15:0] RESET_ACCEL_THRESHOLD = 16'd250;
   localparam logic [15:0] RESET_RELOAD          = 16'd69;
   localparam logic [15:0] RESET_MIN_PERIOD      = 16'd70;

   localparam int MUL_STEPS = 16;
   localparam int DIV_STEPS = 32;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_MOVE      = 2'd1,
      OP_STOP      = 2'd2,
      OP_SET_SPEED = 2'd3
   } opcode_type;

   typedef enum logic [0:0] {
      CSR_ACCEL_RATE      = 1'b0,
      CSR_ACCEL_THRESHOLD = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_STEP,
      ST_MUL_RATE,
      ST_TIME,
      ST_DIV,
      ST_CHECK,
      ST_MUL_WIN,
      ST_RAMP,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/srpg_channels_if.sv -----
// Valid/ready channel interfaces for request, response and CSR writes.
// Depends on srpg_pkg for the opcode and register index types.
interface srpg_req_if;
   logic                   valid;
   logic                   ready;
   srpg_pkg::opcode_type   opcode;
   logic signed [31:0]     move_steps;
   logic [15:0]            speed_interval;

   modport source (output valid, opcode, move_steps, speed_interval, input ready);
   modport sink   (input valid, opcode, move_steps, speed_interval, output ready);
endinterface

interface srpg_rsp_if;
   logic                valid;
   logic                ready;
   logic                step_pulse;
   logic                direction;
   logic signed [31:0]  position;
   logic                running;
   logic                move_done;
   logic                accepted;
   logic [15:0]         period_reload;

   modport source (output valid, step_pulse, direction, position, running, move_done,
                   accepted, period_reload, input ready);
   modport sink   (input valid, step_pulse, direction, position, running, move_done,
                   accepted, period_reload, output ready);
endinterface

interface srpg_csr_if;
   logic                     valid;
   logic                     ready;
   srpg_pkg::csr_index_type  reg_index;
   logic [15:0]              wdata;

   modport source (output valid, reg_index, wdata, input ready);
   modport sink   (input valid, reg_index, wdata, output ready);
endinterface

// ----- rtl/core/stepper_ramp_pulse_generator_core.sv -----
// Stepper ramp pulse generator core: step, position and trapezoidal ramp control.
// Depends on srpg_pkg, the srpg channel interfaces and the assertion macro header.

// One item is worked at a time; each gives exactly one response item. Move, set speed
// and a tick while no move runs go from acceptance straight to the done state. Tick
// (during a move) and stop run the step, rate multiply, time, divide, check and ramp
// states, and a window multiply when the deceleration window has to be evaluated,
// using the bit-serial 16-step shift-add multiplier (once for reload times rate and
// once for the window) and the 32-step restoring divider yielding rate quotient and time slot.
// A new item is accepted while the previous response still waits in the output register.
`include "stepper_ramp_pulse_generator_core_defines.svh"

module stepper_ramp_pulse_generator_core #(
   parameter int TIME_DIVISOR = srpg_pkg::TIME_DIVISOR_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   srpg_req_if.sink   req_chan,
   srpg_rsp_if.source rsp_chan,
   srpg_csr_if.sink   csr_chan
);

   localparam int TD_W = $clog2(TIME_DIVISOR + 1);
   localparam logic [TD_W:0]  TD_CONST = (TD_W + 1)'(TIME_DIVISOR);
   localparam logic [31:0]    TD_WORD  = 32'(TIME_DIVISOR);
   localparam logic [srpg_pkg::CNT_W-1:0] MUL_LAST = srpg_pkg::CNT_W'(srpg_pkg::MUL_STEPS - 1);
   localparam logic [srpg_pkg::CNT_W-1:0] DIV_LAST = srpg_pkg::CNT_W'(srpg_pkg::DIV_STEPS - 1);

   srpg_pkg::state_type state_ff, state_in;

   logic [15:0] accel_rate_ff, accel_threshold_ff;
   logic [15:0] reload_ff, min_period_ff, speed_offset_ff, last_slot_ff;
   logic [31:0] steps_total_ff, steps_done_ff, position_ff, elapsed_ff;
   logic        dir_ff, busy_ff;
   logic        pulse_ff, done_ff, acc_ff;
   logic [srpg_pkg::CNT_W-1:0] cnt_ff;

   logic [47:0]     mul_acc_ff;
   logic [31:0]     mul_mcand_ff;
   logic [15:0]     mul_mplier_ff;
   logic [31:0]     qnum_ff, qrem_ff, snum_ff;
   logic [TD_W-1:0] srem_ff;

   logic        rsp_valid_ff;
   logic        rsp_pulse_ff, rsp_dir_ff, rsp_running_ff, rsp_done_ff, rsp_acc_ff;
   logic [31:0] rsp_position_ff;
   logic [15:0] rsp_reload_ff;

   logic        req_ready, load_rsp, req_fire, csr_fire;
   logic        step_go, slot_ne, ramp_up, ramp_down, q_ge, s_ge;
   logic [15:0] reload_step, set_offset;
   logic [31:0] elapsed_next, remaining, quot_final;
   logic [47:0] mul_acc_next;
   logic [32:0] q_trial;
   logic [TD_W:0] s_trial;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         srpg_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_chan.opcode)
                  srpg_pkg::OP_TICK: state_in = busy_ff ? srpg_pkg::ST_STEP : srpg_pkg::ST_DONE;
                  srpg_pkg::OP_STOP: state_in = srpg_pkg::ST_STEP;
                  default:           state_in = srpg_pkg::ST_DONE;
               endcase
            end
         end
         srpg_pkg::ST_STEP:     state_in = srpg_pkg::ST_MUL_RATE;
         srpg_pkg::ST_MUL_RATE: if (cnt_ff == MUL_LAST) state_in = srpg_pkg::ST_TIME;
         srpg_pkg::ST_TIME:     state_in = srpg_pkg::ST_DIV;
         srpg_pkg::ST_DIV:      if (cnt_ff == DIV_LAST) state_in = srpg_pkg::ST_CHECK;
         srpg_pkg::ST_CHECK: begin
            state_in = (reload_ff < accel_threshold_ff && slot_ne) ?
                       srpg_pkg::ST_MUL_WIN : srpg_pkg::ST_RAMP;
         end
         srpg_pkg::ST_MUL_WIN:  if (cnt_ff == MUL_LAST) state_in = srpg_pkg::ST_RAMP;
         srpg_pkg::ST_RAMP:     state_in = srpg_pkg::ST_DONE;
         srpg_pkg::ST_DONE:     if (load_rsp) state_in = srpg_pkg::ST_IDLE;
         default:               state_in = srpg_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- control outputs
   always_comb begin
      req_ready = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         srpg_pkg::ST_IDLE: req_ready = 1'b1;
         srpg_pkg::ST_DONE: load_rsp  = !rsp_valid_ff || rsp_chan.ready;
         default: begin
            req_ready = 1'b0;
            load_rsp  = 1'b0;
         end
      endcase
   end

   assign req_chan.ready = req_ready;
   assign csr_chan.ready = 1'b1;
   assign req_fire       = req_chan.valid && req_ready;
   assign csr_fire       = csr_chan.valid;

   // ---------------------------------------------------------------- datapath helpers
   assign step_go     = steps_done_ff < steps_total_ff;
   assign reload_step = (step_go || speed_offset_ff == 16'd0) ?
                        reload_ff : accel_threshold_ff - 16'd1;
   assign set_offset  = (req_chan.speed_interval < accel_threshold_ff) ?
                        accel_threshold_ff - req_chan.speed_interval : 16'd0;

   assign mul_acc_next = {mul_acc_ff[46:0], 1'b0} +
                         (mul_mplier_ff[15] ? {16'd0, mul_mcand_ff} : 48'd0);
   assign elapsed_next = elapsed_ff + (pulse_ff ? mul_acc_ff[31:0] : 32'd0);

   assign q_trial = {qrem_ff, qnum_ff[31]};
   assign q_ge    = q_trial >= {1'b0, mul_acc_ff[31:0]};
   assign s_trial = {srem_ff, snum_ff[31]};
   assign s_ge    = s_trial >= TD_CONST;

   assign quot_final = (mul_acc_ff[31:0] == 32'd0) ? 32'hFFFF_FFFF : qnum_ff;
   assign slot_ne    = snum_ff != {16'd0, last_slot_ff};
   assign remaining  = steps_total_ff - steps_done_ff;
   assign ramp_up    = reload_ff < accel_threshold_ff && slot_ne &&
                       {16'd0, remaining} <= mul_acc_ff;
   assign ramp_down  = !ramp_up && reload_ff > min_period_ff && slot_ne;

   // ---------------------------------------------------------------- control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= srpg_pkg::ST_IDLE;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
         accel_rate_ff      <= srpg_pkg::RESET_ACCEL_RATE;
         accel_threshold_ff <= srpg_pkg::RESET_ACCEL_THRESHOLD;
         reload_ff          <= srpg_pkg::RESET_RELOAD;
         min_period_ff      <= srpg_pkg::RESET_MIN_PERIOD;
         speed_offset_ff    <= 16'd0;
         steps_total_ff     <= 32'd0;
         steps_done_ff      <= 32'd0;
         position_ff        <= 32'd0;
         dir_ff             <= 1'b0;
         busy_ff            <= 1'b0;
         elapsed_ff         <= 32'd0;
         last_slot_ff       <= 16'd0;
         pulse_ff           <= 1'b0;
         done_ff            <= 1'b0;
         acc_ff             <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= load_rsp || (rsp_valid_ff && !rsp_chan.ready);

         if (csr_fire) begin
            case (csr_chan.reg_index)
               srpg_pkg::CSR_ACCEL_RATE:      accel_rate_ff      <= csr_chan.wdata;
               srpg_pkg::CSR_ACCEL_THRESHOLD: accel_threshold_ff <= csr_chan.wdata;
               default:                       accel_rate_ff      <= accel_rate_ff;
            endcase
         end

         case (state_ff)
            srpg_pkg::ST_IDLE: begin
               if (req_fire) begin
                  pulse_ff <= 1'b0;
                  done_ff  <= 1'b0;
                  acc_ff   <= 1'b0;
                  case (req_chan.opcode)
                     srpg_pkg::OP_MOVE: begin
                        if (!busy_ff) begin
                           dir_ff         <= !req_chan.move_steps[31];
                           steps_total_ff <= req_chan.move_steps[31] ?
                                             32'd0 - req_chan.move_steps :
                                             req_chan.move_steps;
                           steps_done_ff  <= 32'd0;
                           busy_ff        <= 1'b1;
                           elapsed_ff     <= 32'd0;
                           acc_ff         <= 1'b1;
                        end
                     end
                     srpg_pkg::OP_STOP: steps_done_ff <= steps_total_ff;
                     srpg_pkg::OP_SET_SPEED: begin
                        if (req_chan.speed_interval != 16'd0) begin
                           min_period_ff   <= req_chan.speed_interval;
                           speed_offset_ff <= set_offset;
                           reload_ff       <= req_chan.speed_interval + set_offset - 16'd1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            srpg_pkg::ST_STEP: begin
               cnt_ff <= '0;
               if (step_go) begin
                  pulse_ff      <= 1'b1;
                  steps_done_ff <= steps_done_ff + 32'd1;
                  position_ff   <= dir_ff ? position_ff + 32'd1 : position_ff - 32'd1;
               end else begin
                  done_ff   <= busy_ff;
                  busy_ff   <= 1'b0;
                  reload_ff <= reload_step;
               end
            end
            srpg_pkg::ST_MUL_RATE, srpg_pkg::ST_DIV, srpg_pkg::ST_MUL_WIN: begin
               cnt_ff <= cnt_ff + 1'b1;
            end
            srpg_pkg::ST_TIME: begin
               cnt_ff     <= '0;
               elapsed_ff <= elapsed_next;
            end
            srpg_pkg::ST_CHECK: cnt_ff <= '0;
            srpg_pkg::ST_RAMP: begin
               if (ramp_up) begin
                  last_slot_ff <= snum_ff[15:0];
                  reload_ff    <= reload_ff + 16'd1;
               end else if (ramp_down) begin
                  last_slot_ff <= snum_ff[15:0];
                  reload_ff    <= reload_ff - 16'd1;
               end
            end
            default: cnt_ff <= cnt_ff;
         endcase
      end
   end

   // ---------------------------------------------------------------- serial units and item
   always_ff @(posedge clock) begin
      case (state_ff)
         srpg_pkg::ST_STEP: begin
            mul_acc_ff    <= 48'd0;
            mul_mcand_ff  <= {16'd0, accel_rate_ff};
            mul_mplier_ff <= reload_step;
         end
         srpg_pkg::ST_MUL_RATE, srpg_pkg::ST_MUL_WIN: begin
            mul_acc_ff    <= mul_acc_next;
            mul_mplier_ff <= {mul_mplier_ff[14:0], 1'b0};
         end
         srpg_pkg::ST_TIME: begin
            qnum_ff <= TD_WORD;
            qrem_ff <= 32'd0;
            snum_ff <= elapsed_next;
            srem_ff <= '0;
         end
         srpg_pkg::ST_DIV: begin
            qnum_ff <= {qnum_ff[30:0], q_ge};
            qrem_ff <= q_ge ? 32'(q_trial - {1'b0, mul_acc_ff[31:0]}) : q_trial[31:0];
            snum_ff <= {snum_ff[30:0], s_ge};
            srem_ff <= s_ge ? TD_W'(s_trial - TD_CONST) : s_trial[TD_W-1:0];
         end
         srpg_pkg::ST_CHECK: begin
            mul_acc_ff    <= 48'd0;
            mul_mcand_ff  <= quot_final;
            mul_mplier_ff <= accel_threshold_ff - reload_ff;
         end
         srpg_pkg::ST_DONE: begin
            if (load_rsp) begin
               rsp_pulse_ff    <= pulse_ff;
               rsp_dir_ff      <= dir_ff;
               rsp_position_ff <= position_ff;
               rsp_running_ff  <= busy_ff;
               rsp_done_ff     <= done_ff;
               rsp_acc_ff      <= acc_ff;
               rsp_reload_ff   <= reload_ff;
            end
         end
         default: mul_mplier_ff <= mul_mplier_ff;
      endcase
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.step_pulse    = rsp_pulse_ff;
   assign rsp_chan.direction     = rsp_dir_ff;
   assign rsp_chan.position      = rsp_position_ff;
   assign rsp_chan.running       = rsp_running_ff;
   assign rsp_chan.move_done     = rsp_done_ff;
   assign rsp_chan.accepted      = rsp_acc_ff;
   assign rsp_chan.period_reload = rsp_reload_ff;

   // ---------------------------------------------------------------- assertions
   `SRPG_ASSERT_HOLDS(a_done_le_total, clock, reset,
                      steps_done_ff <= steps_total_ff, "steps done past total")
   `SRPG_ASSERT_IMPLIES(a_fall_flags_done, clock, reset,
                        $fell(busy_ff), done_ff, "move ended without done flag")
   `SRPG_ASSERT_IMPLIES(a_rise_clears, clock, reset, $rose(busy_ff),
                        steps_done_ff == 32'd0 && elapsed_ff == 32'd0,
                        "move started with stale counters")

endmodule
